// ===== hdl/stx_etx_frame_encoder_crc16_assert.svh =====
// Assertion macros for the STX/ETX frame encoder checker.
// Included by the checker file; no other dependencies.
`ifndef STX_ETX_FRAME_ENCODER_CRC16_ASSERT_SVH
`define STX_ETX_FRAME_ENCODER_CRC16_ASSERT_SVH

// Same-cycle implication, disabled while rstn is low.
`define SEF_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sef assertion failed");

// Next-cycle implication, disabled while rstn is low.
`define SEF_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sef assertion failed");

`endif

// ===== hdl/sef_pkg.sv =====
// Package for the STX/ETX frame encoder: types, constants and the CRC step.
// No dependencies.
package sef_pkg;

    localparam logic [7:0]  FRAME_STX    = 8'h02;
    localparam logic [7:0]  FRAME_ETX    = 8'h03;
    localparam logic [7:0]  LEN_OVERHEAD = 8'd4;
    localparam logic [15:0] CRC_POLY     = 16'h1021;
    localparam logic [7:0]  TYPE_RESET   = 8'd102;
    localparam logic [7:0]  PREFIX_RESET = 8'h05;

    localparam logic CFG_PACKET_TYPE   = 1'b0;
    localparam logic CFG_REPORT_PREFIX = 1'b1;

    typedef struct packed {
        logic [7:0] payload_len;
        logic [7:0] data_byte;
    } item_t;

    typedef enum logic [2:0] {
        PH_PREFIX,
        PH_STX,
        PH_LEN,
        PH_TYPE,
        PH_DATA,
        PH_CRCL,
        PH_CRCH,
        PH_ETX
    } phase_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== hdl/stx_etx_frame_encoder_crc16.sv =====
// Top level of the STX/ETX frame encoder with CRC-16 (poly 0x1021, init 0).
// Depends on sef_pkg, sef_in_reg and sef_framer.
//
//  Channel   Direction  Payload
//  s_        in         tdata[7:0] data_byte, tdata[15:8] payload_len
//  m_        out        tdata[7:0] out_byte, tlast frame_end
//  cfg_      in         index 0 packet_type, index 1 report_prefix
//
// One output item leaves per cycle unless m_ stalls. A mid-frame input item
// gives one output item, so items flow at one per cycle. The first item of
// a frame gives the prefix, STX, LEN, type and data bytes, and the last
// adds the CRC bytes, low first, and ETX, in the order set by sef_framer.
// Reset is synchronous and clears the sequencer, the CRC and both registers'
// valid flags. A stall on m_ holds the output register; the input register
// then holds one more item.
module stx_etx_frame_encoder_crc16 (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] data_byte, [15:8] payload_len
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_wdata
);

    logic           item_valid;
    logic           consume;
    sef_pkg::item_t item;

    sef_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .consume    (consume),
        .item_valid (item_valid),
        .item       (item)
    );

    sef_framer u_framer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .item_valid (item_valid),
        .item       (item),
        .consume    (consume),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

// ===== hdl/sef_in_reg.sv =====
// Input register of the frame encoder: holds one accepted item until framed.
// Depends on sef_pkg.
module sef_in_reg (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [15:0]   s_tdata,
    input  logic          consume,
    output logic          item_valid,
    output sef_pkg::item_t item
);

    logic           valid_reg, valid_next;
    sef_pkg::item_t item_reg;

    assign s_tready   = !valid_reg || consume;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (consume) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= sef_pkg::item_t'(s_tdata);
        end
    end

endmodule

// ===== hdl/sef_framer.sv =====
// Frame sequencer of the encoder: configuration registers, running CRC,
// byte counter and output register. Depends on sef_pkg.
module sef_framer (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_we,
    input  logic           cfg_index,
    input  logic [7:0]     cfg_wdata,
    input  logic           item_valid,
    input  sef_pkg::item_t item,
    output logic           consume,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,
    output logic           m_tlast
);

    sef_pkg::phase_t phase_reg, phase_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  left_reg, left_next;
    logic [7:0]  type_reg, prefix_reg;
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  m_byte_reg, m_byte_next;
    logic        m_last_reg, m_last_next;
    logic        out_free, emit;
    logic [7:0]  plen_eff, len_byte;

    assign out_free = !m_valid_reg || m_tready;
    assign plen_eff = (item.payload_len == 8'd0) ? 8'd1 : item.payload_len;
    assign len_byte = plen_eff + sef_pkg::LEN_OVERHEAD;

    always_comb begin
        case (phase_reg)
            sef_pkg::PH_CRCL, sef_pkg::PH_CRCH, sef_pkg::PH_ETX: emit = out_free;
            default: emit = out_free && item_valid;
        endcase
    end

    assign consume = emit && (phase_reg == sef_pkg::PH_DATA);

    always_comb begin
        phase_next   = phase_reg;
        crc_next     = crc_reg;
        left_next    = left_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_byte_next  = m_byte_reg;
        m_last_next  = m_last_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_last_next  = 1'b0;
            case (phase_reg)
                sef_pkg::PH_PREFIX: begin
                    m_byte_next = prefix_reg;
                    phase_next  = sef_pkg::PH_STX;
                end
                sef_pkg::PH_STX: begin
                    m_byte_next = sef_pkg::FRAME_STX;
                    phase_next  = sef_pkg::PH_LEN;
                end
                sef_pkg::PH_LEN: begin
                    m_byte_next = len_byte;
                    crc_next    = sef_pkg::crc_feed(16'h0000, len_byte);
                    left_next   = plen_eff;
                    phase_next  = sef_pkg::PH_TYPE;
                end
                sef_pkg::PH_TYPE: begin
                    m_byte_next = type_reg;
                    crc_next    = sef_pkg::crc_feed(crc_reg, type_reg);
                    phase_next  = sef_pkg::PH_DATA;
                end
                sef_pkg::PH_DATA: begin
                    m_byte_next = item.data_byte;
                    crc_next    = sef_pkg::crc_feed(crc_reg, item.data_byte);
                    left_next   = left_reg - 8'd1;
                    phase_next  = (left_reg == 8'd1) ? sef_pkg::PH_CRCL : sef_pkg::PH_DATA;
                end
                sef_pkg::PH_CRCL: begin
                    m_byte_next = crc_reg[7:0];
                    phase_next  = sef_pkg::PH_CRCH;
                end
                sef_pkg::PH_CRCH: begin
                    m_byte_next = crc_reg[15:8];
                    phase_next  = sef_pkg::PH_ETX;
                end
                sef_pkg::PH_ETX: begin
                    m_byte_next = sef_pkg::FRAME_ETX;
                    m_last_next = 1'b1;
                    phase_next  = sef_pkg::PH_PREFIX;
                end
                default: begin
                    phase_next = sef_pkg::PH_PREFIX;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= sef_pkg::PH_PREFIX;
            crc_reg     <= 16'h0000;
            left_reg    <= 8'd0;
            m_valid_reg <= 1'b0;
            type_reg    <= sef_pkg::TYPE_RESET;
            prefix_reg  <= sef_pkg::PREFIX_RESET;
        end else begin
            phase_reg   <= phase_next;
            crc_reg     <= crc_next;
            left_reg    <= left_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    sef_pkg::CFG_PACKET_TYPE:   type_reg   <= cfg_wdata;
                    sef_pkg::CFG_REPORT_PREFIX: prefix_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_byte_reg <= m_byte_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_byte_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ===== hdl/sef_checker.sv =====
// Port-level checker for the STX/ETX frame encoder, bound to the top level.
// Depends on stx_etx_frame_encoder_crc16_assert.svh and sef_pkg.
`include "stx_etx_frame_encoder_crc16_assert.svh"

module sef_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    `SEF_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    `SEF_ASSERT_IMP(a_last_is_etx, aclk, aresetn, m_tvalid && m_tlast, m_tdata == sef_pkg::FRAME_ETX)
    `SEF_ASSERT_NXT(a_reset_clears, aclk, 1'b1, !aresetn, !m_tvalid)

endmodule

bind stx_etx_frame_encoder_crc16 sef_checker u_sef_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
